// ===== hw/rtl/dbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dbc_pkg: shared types and constants of the disk block cache controller
// Holds the word formats of both channels, the job word that goes from the
// front to the back, request codes and default parameter values.
// ----------------------------------------------------------------------------
package dbc_pkg;

  localparam int DEF_NUM_ENTRIES       = 64;
  localparam int DEF_BLOCK_OFFSET_BITS = 16;

  localparam int ADDR_W   = 48;
  localparam int TAG_W    = 32;
  localparam int OFFSET_W = 16;
  localparam int SLOT_W   = 6;
  localparam int REQ_W    = 2;

  // Depth of the job queue between the front and the back (a power of two).
  localparam int QUEUE_DEPTH = 2;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] byte_address;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [OFFSET_W-1:0] block_offset;
    logic                hit;
    logic                writeback_needed;
    logic [TAG_W-1:0]    writeback_block;
    logic                fill_needed;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [TAG_W-1:0]    blk;
    logic [OFFSET_W-1:0] offset;
  } job_t;

endpackage

// ===== hw/rtl/dbc_chan_if.sv =====
// ----------------------------------------------------------------------------
// dbc_chan_if: valid/ready channel
// Carries one word of type T per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface dbc_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/dbc_front.sv =====
// ----------------------------------------------------------------------------
// dbc_front: request intake
// Accepts request words, drops unknown request codes and splits the byte
// address into block number and offset inside the block.
// ----------------------------------------------------------------------------
module dbc_front #(
  parameter int BLOCK_OFFSET_BITS = dbc_pkg::DEF_BLOCK_OFFSET_BITS
) (
  dbc_chan_if.sink      in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output dbc_pkg::job_t push_job
);

  localparam logic [dbc_pkg::ADDR_W-1:0] OFFSET_MASK =
    (dbc_pkg::ADDR_W'(1) << BLOCK_OFFSET_BITS) - dbc_pkg::ADDR_W'(1);

  logic                       known_req;
  logic [dbc_pkg::ADDR_W-1:0] blk_full;
  logic [dbc_pkg::ADDR_W-1:0] offset_full;

  always_comb begin
    known_req = (in_ch.data.req_type == dbc_pkg::REQ_READ)  ||
                (in_ch.data.req_type == dbc_pkg::REQ_WRITE) ||
                (in_ch.data.req_type == dbc_pkg::REQ_FLUSH);
    blk_full    = in_ch.data.byte_address >> BLOCK_OFFSET_BITS;
    offset_full = in_ch.data.byte_address & OFFSET_MASK;
  end

  // An unknown request code is taken and discarded without reaching the back.
  assign in_ch.ready     = push_ready;
  assign push_valid      = in_ch.valid && known_req;
  assign push_job.req    = in_ch.data.req_type;
  assign push_job.blk    = blk_full[dbc_pkg::TAG_W-1:0];
  assign push_job.offset = offset_full[dbc_pkg::OFFSET_W-1:0];

endmodule

// ===== hw/rtl/dbc_queue.sv =====
// ----------------------------------------------------------------------------
// dbc_queue: job queue
// Small FIFO that decouples request intake from the cache engine.
// ----------------------------------------------------------------------------
module dbc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dbc_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dbc_pkg::job_t pop_job
);

  localparam int DEPTH = dbc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dbc_pkg::job_t    slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/dbc_back.sv =====
// ----------------------------------------------------------------------------
// dbc_back: cache engine
// Walks the tag memory for lookups and flushes, applies the replacement
// policy, keeps entry status and drives the registered result channel.
// ----------------------------------------------------------------------------
module dbc_back #(
  parameter int NUM_ENTRIES = dbc_pkg::DEF_NUM_ENTRIES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  dbc_pkg::job_t job,
  dbc_chan_if.source    out_ch
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_READY,
    ST_DIRTY
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_VICTIM,
    S_APPLY,
    S_FL_CHECK,
    S_FL_EMIT,
    S_FL_NONE
  } state_t;

  state_t                     state_r;
  dbc_pkg::job_t              job_r;
  logic [dbc_pkg::TAG_W-1:0]  tag_mem [NUM_ENTRIES];
  logic [dbc_pkg::TAG_W-1:0]  tag_q_r;
  status_t                    status_r [NUM_ENTRIES];
  logic [IDX_W-1:0]           victim_r;
  logic [IDX_W-1:0]           victim_nxt;
  logic [CNT_W-1:0]           dirty_cnt_r;
  logic [CNT_W-1:0]           dirty_cnt_nxt;
  logic [IDX_W-1:0]           cmp_idx_r;
  logic                       have_empty_r;
  logic [IDX_W-1:0]           empty_idx_r;
  logic [IDX_W-1:0]           found_r;
  logic                       hit_r;
  logic                       wb_r;
  logic [dbc_pkg::TAG_W-1:0]  wbblk_r;
  logic                       fill_r;
  logic                       out_v_r;
  dbc_pkg::out_word_t         out_d_r;

  logic                       out_free;
  logic                       out_load;
  logic                       cmp_hit;
  logic                       cmp_empty;
  logic                       old_dirty;
  logic                       new_dirty;
  logic                       fl_last;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic                       tag_we;

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;
  assign job_ready    = (state_r == S_IDLE);
  assign out_free     = !out_v_r || out_ch.ready;

  always_comb begin
    cmp_empty  = (status_r[cmp_idx_r] == ST_EMPTY);
    cmp_hit    = !cmp_empty && (tag_q_r == job_r.blk);
    victim_nxt = (victim_r == LAST_IDX) ? '0 : victim_r + 1'b1;
    old_dirty  = (status_r[found_r] == ST_DIRTY);
    new_dirty  = (job_r.req == dbc_pkg::REQ_WRITE) || (hit_r && old_dirty);
    fl_last    = (dirty_cnt_r == CNT_W'(1));
    tag_we     = (state_r == S_APPLY) && out_free && fill_r;
    out_load   = out_free && ((state_r == S_APPLY) || (state_r == S_FL_EMIT) ||
                              (state_r == S_FL_NONE));

    dirty_cnt_nxt = dirty_cnt_r;
    if (new_dirty && !old_dirty) begin
      dirty_cnt_nxt = dirty_cnt_r + 1'b1;
    end else if (!new_dirty && old_dirty) begin
      dirty_cnt_nxt = dirty_cnt_r - 1'b1;
    end
  end

  // Tag memory read port. During a scan the read of the next entry overlaps
  // the compare of the current one; after the last entry the victim's tag is
  // fetched in case it has to be written back.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        rd_en = job_valid;
      end
      S_SCAN: begin
        rd_en   = !cmp_hit;
        rd_addr = (cmp_idx_r == LAST_IDX) ? victim_r : cmp_idx_r + 1'b1;
      end
      S_FL_CHECK: begin
        rd_en   = (status_r[cmp_idx_r] == ST_DIRTY);
        rd_addr = cmp_idx_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_q_r <= tag_mem[rd_addr];
    end
    if (tag_we) begin
      tag_mem[found_r] <= job_r.blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_v_r     <= 1'b0;
      victim_r    <= '0;
      dirty_cnt_r <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        status_r[i] <= ST_EMPTY;
      end
    end else begin
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r        <= job;
            cmp_idx_r    <= '0;
            have_empty_r <= 1'b0;
            if (job.req == dbc_pkg::REQ_FLUSH) begin
              state_r <= (dirty_cnt_r == '0) ? S_FL_NONE : S_FL_CHECK;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmp_hit) begin
            found_r <= cmp_idx_r;
            hit_r   <= 1'b1;
            wb_r    <= 1'b0;
            wbblk_r <= '0;
            fill_r  <= 1'b0;
            state_r <= S_APPLY;
          end else begin
            if (cmp_empty && !have_empty_r) begin
              have_empty_r <= 1'b1;
              empty_idx_r  <= cmp_idx_r;
            end
            if (cmp_idx_r == LAST_IDX) begin
              hit_r   <= 1'b0;
              wb_r    <= 1'b0;
              wbblk_r <= '0;
              fill_r  <= 1'b1;
              if (have_empty_r) begin
                found_r <= empty_idx_r;
                state_r <= S_APPLY;
              end else if (cmp_empty) begin
                found_r <= cmp_idx_r;
                state_r <= S_APPLY;
              end else begin
                found_r  <= victim_r;
                victim_r <= victim_nxt;
                state_r  <= S_VICTIM;
              end
            end else begin
              cmp_idx_r <= cmp_idx_r + 1'b1;
            end
          end
        end
        S_VICTIM: begin
          if (status_r[found_r] == ST_DIRTY) begin
            wb_r    <= 1'b1;
            wbblk_r <= tag_q_r;
          end
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            out_d_r.slot             <= dbc_pkg::SLOT_W'(found_r);
            out_d_r.block_offset     <= job_r.offset;
            out_d_r.hit              <= hit_r;
            out_d_r.writeback_needed <= wb_r;
            out_d_r.writeback_block  <= wbblk_r;
            out_d_r.fill_needed      <= fill_r;
            out_d_r.last             <= 1'b1;
            status_r[found_r]        <= new_dirty ? ST_DIRTY : ST_READY;
            dirty_cnt_r              <= dirty_cnt_nxt;
            state_r                  <= S_IDLE;
          end
        end
        S_FL_CHECK: begin
          // The dirty count guarantees a dirty entry further on.
          if (status_r[cmp_idx_r] == ST_DIRTY) begin
            state_r <= S_FL_EMIT;
          end else begin
            cmp_idx_r <= cmp_idx_r + 1'b1;
          end
        end
        S_FL_EMIT: begin
          if (out_free) begin
            out_d_r.slot             <= dbc_pkg::SLOT_W'(cmp_idx_r);
            out_d_r.block_offset     <= '0;
            out_d_r.hit              <= 1'b0;
            out_d_r.writeback_needed <= 1'b1;
            out_d_r.writeback_block  <= tag_q_r;
            out_d_r.fill_needed      <= 1'b0;
            out_d_r.last             <= fl_last;
            status_r[cmp_idx_r]      <= ST_READY;
            dirty_cnt_r              <= dirty_cnt_r - 1'b1;
            if (fl_last) begin
              state_r <= S_IDLE;
            end else begin
              cmp_idx_r <= cmp_idx_r + 1'b1;
              state_r   <= S_FL_CHECK;
            end
          end
        end
        S_FL_NONE: begin
          if (out_free) begin
            out_d_r.slot             <= '0;
            out_d_r.block_offset     <= '0;
            out_d_r.hit              <= 1'b0;
            out_d_r.writeback_needed <= 1'b0;
            out_d_r.writeback_block  <= '0;
            out_d_r.fill_needed      <= 1'b0;
            out_d_r.last             <= 1'b1;
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/disk_block_cache_controller.sv =====
// ----------------------------------------------------------------------------
// disk_block_cache_controller: tag and policy engine of a disk block cache
// Fully associative write-back cache with round-robin replacement; reports
// the slot to use, write-backs and fills for each request.
// ----------------------------------------------------------------------------
// Requests enter a two-word queue and are then served one at a time by an
// engine that walks the tag memory one entry per clock. A read or write
// walks it until a hit or the last entry and, on a miss with no empty
// entry, fetches the victim's tag before its result word. A flush checks
// each entry up to the last dirty one and gives one result word per dirty
// entry, or a single word when nothing is dirty. Each request yields its
// results in order on the out_res channel, the final one marked by last;
// request code three is accepted and dropped. Results wait in an output
// register, so a stalled sink holds the engine but the queue still takes
// new requests while it has room.
module disk_block_cache_controller #(
  parameter int NUM_ENTRIES       = dbc_pkg::DEF_NUM_ENTRIES,
  parameter int BLOCK_OFFSET_BITS = dbc_pkg::DEF_BLOCK_OFFSET_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  dbc_chan_if.sink   in_req,
  dbc_chan_if.source out_res
);

  logic          push_valid;
  logic          push_ready;
  dbc_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  dbc_pkg::job_t pop_job;

  dbc_front #(
    .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS)
  ) u_front (
    .in_ch      (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  dbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  dbc_back #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_ch    (out_res)
  );

endmodule

// ===== test/dbc_cache_checker.sv =====
// ----------------------------------------------------------------------------
// dbc_cache_checker: result checker for the disk block cache controller
// Watches the request and result channels, keeps its own copy of the tag and
// status memory and the victim pointer, works out the result words of every
// accepted request and compares each accepted result word with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module dbc_cache_checker
  import dbc_pkg::*;
#(
  parameter int NUM_ENTRIES       = DEF_NUM_ENTRIES,
  parameter int BLOCK_OFFSET_BITS = DEF_BLOCK_OFFSET_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  logic      req_ready,
  input  in_word_t  req_word,
  input  logic      res_valid,
  input  logic      res_ready,
  input  out_word_t res_word,
  output int        mismatches,
  output int        results_owed,
  output int        results_checked,
  output int        hits,
  output int        dirty_evictions,
  output int        flush_writebacks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ENTRY_EMPTY = 2'd0,
    ENTRY_READY = 2'd1,
    ENTRY_DIRTY = 2'd2
  } entry_state_e;

  logic [TAG_W-1:0] entry_tag   [NUM_ENTRIES];
  entry_state_e     entry_state [NUM_ENTRIES];
  int               victim;
  out_word_t        pending_results[$];

  int mismatch_count  = 0;
  int owed_count      = 0;
  int checked_count   = 0;
  int hit_count       = 0;
  int eviction_count  = 0;
  int writeback_count = 0;

  assign mismatches       = mismatch_count;
  assign results_owed     = owed_count;
  assign results_checked  = checked_count;
  assign hits             = hit_count;
  assign dirty_evictions  = eviction_count;
  assign flush_writebacks = writeback_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result word %0d: %s", $realtime, checked_count, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string field, input logic [TAG_W-1:0] got,
                               input logic [TAG_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    end
  endtask

  // Works out the result words that one request causes and updates the
  // shadow tag state the same way the engine does.
  task automatic predict_cache_results(input in_word_t w);
    logic [ADDR_W-1:0]   shifted;
    logic [ADDR_W-1:0]   offset_full;
    logic [TAG_W-1:0]    blk;
    int                  found;
    int                  final_dirty;
    out_word_t           r;
    shifted     = w.byte_address >> BLOCK_OFFSET_BITS;
    blk         = shifted[TAG_W-1:0];
    offset_full = w.byte_address & ((ADDR_W'(1) << BLOCK_OFFSET_BITS) - ADDR_W'(1));
    found       = -1;
    final_dirty = -1;
    case (w.req_type)
      REQ_FLUSH: begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (entry_state[i] == ENTRY_DIRTY) final_dirty = i;
        end
        if (final_dirty < 0) begin
          r      = '0;
          r.last = 1'b1;
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (entry_state[i] == ENTRY_DIRTY) begin
              r                  = '0;
              r.slot             = SLOT_W'(i);
              r.writeback_needed = 1'b1;
              r.writeback_block  = entry_tag[i];
              r.last             = (i == final_dirty);
              pending_results.push_back(r);
              entry_state[i] = ENTRY_READY;
              writeback_count++;
            end
          end
        end
      end
      REQ_READ, REQ_WRITE: begin
        r              = '0;
        r.block_offset = offset_full[OFFSET_W-1:0];
        r.last         = 1'b1;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (found < 0 && entry_state[i] != ENTRY_EMPTY && entry_tag[i] == blk) found = i;
        end
        if (found >= 0) begin
          r.hit = 1'b1;
          hit_count++;
        end else begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (found < 0 && entry_state[i] == ENTRY_EMPTY) found = i;
          end
          // Only a full cache consults the round-robin pointer.
          if (found < 0) begin
            found  = victim;
            victim = (victim == NUM_ENTRIES - 1) ? 0 : victim + 1;
            if (entry_state[found] == ENTRY_DIRTY) begin
              r.writeback_needed = 1'b1;
              r.writeback_block  = entry_tag[found];
              eviction_count++;
            end
          end
          r.fill_needed      = 1'b1;
          entry_tag[found]   = blk;
          entry_state[found] = ENTRY_READY;
        end
        if (w.req_type == REQ_WRITE) entry_state[found] = ENTRY_DIRTY;
        r.slot = SLOT_W'(found);
        pending_results.push_back(r);
      end
      default: begin
        // The unused code is dropped without a result.
      end
    endcase
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result word arrived with none owed");
    end else begin
      want = pending_results.pop_front();
      compare_field("slot", TAG_W'(got.slot), TAG_W'(want.slot));
      compare_field("block_offset", TAG_W'(got.block_offset), TAG_W'(want.block_offset));
      compare_field("hit", TAG_W'(got.hit), TAG_W'(want.hit));
      compare_field("writeback_needed", TAG_W'(got.writeback_needed),
                    TAG_W'(want.writeback_needed));
      compare_field("writeback_block", got.writeback_block, want.writeback_block);
      compare_field("fill_needed", TAG_W'(got.fill_needed), TAG_W'(want.fill_needed));
      compare_field("last", TAG_W'(got.last), TAG_W'(want.last));
    end
    checked_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        entry_tag[i]   = '0;
        entry_state[i] = ENTRY_EMPTY;
      end
      victim = 0;
      pending_results.delete();
    end else begin
      if (req_valid && req_ready) predict_cache_results(req_word);
      if (res_valid && res_ready) check_result(res_word);
    end
    owed_count <= pending_results.size();
  end

endmodule

// ===== test/disk_block_cache_controller_tb.sv =====
// ----------------------------------------------------------------------------
// disk_block_cache_controller_tb: regression bench of the disk block cache
// Sends a directed opening and then random read, write, flush and unused
// requests drawn from a block pool large enough to force evictions, with
// random idling on both channels; a checker beside the block compares every
// result word and the top gives the verdict.
// ----------------------------------------------------------------------------
module disk_block_cache_controller_tb;
  import dbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES       = DEF_NUM_ENTRIES;
  localparam int BLOCK_OFFSET_BITS = DEF_BLOCK_OFFSET_BITS;
  localparam int RANDOM_ITEMS      = 154;
  localparam int STEADY_ITEMS      = 30;
  localparam int POOL_SIZE         = 128;
  localparam int HOT_BLOCKS        = 24;
  localparam int WATCHDOG_LIMIT    = 1000;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic sink_ready = 1'b0;
  logic steady     = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   words_sent = 0;

  int mismatches;
  int results_owed;
  int results_checked;
  int hits;
  int dirty_evictions;
  int flush_writebacks;

  logic [TAG_W-1:0] block_pool [POOL_SIZE];

  dbc_chan_if #(.T(in_word_t))  in_req ();
  dbc_chan_if #(.T(out_word_t)) out_res ();

  assign out_res.ready = sink_ready;

  disk_block_cache_controller #(
    .NUM_ENTRIES      (NUM_ENTRIES),
    .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res)
  );

  dbc_cache_checker #(
    .NUM_ENTRIES      (NUM_ENTRIES),
    .BLOCK_OFFSET_BITS(BLOCK_OFFSET_BITS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (in_req.valid),
    .req_ready       (in_req.ready),
    .req_word        (in_req.data),
    .res_valid       (out_res.valid),
    .res_ready       (out_res.ready),
    .res_word        (out_res.data),
    .mismatches      (mismatches),
    .results_owed    (results_owed),
    .results_checked (results_checked),
    .hits            (hits),
    .dirty_evictions (dirty_evictions),
    .flush_writebacks(flush_writebacks)
  );

  always #4 clk = ~clk;

  // The result sink stalls in short random bursts until the steady phase.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ADDR_W-1:0] to_address(input logic [TAG_W-1:0] blk,
                                                   input logic [OFFSET_W-1:0] offs);
    return (ADDR_W'(blk) << BLOCK_OFFSET_BITS) | ADDR_W'(offs);
  endfunction

  // Called just after a rising edge; returns at the edge that takes the word.
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= '{req_type: kind, byte_address: addr};
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  initial begin
    int                  pick;
    logic [TAG_W-1:0]    blk;
    logic [REQ_W-1:0]    kind;
    in_req.valid <= 1'b0;
    in_req.data  <= '0;
    for (int i = 0; i < POOL_SIZE; i++) block_pool[i] = $urandom;
    block_pool[0] = '0;
    block_pool[1] = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty flush, hits and misses at the address extremes,
    // the unused code, flushes with and without dirty entries.
    send_word(REQ_FLUSH, '0);
    send_word(REQ_READ, to_address(32'h0000_0000, 16'h0000));
    send_word(REQ_READ, to_address(32'h0000_0000, 16'hFFFF));
    send_word(REQ_WRITE, '1);
    send_word(REQ_WRITE, to_address(32'h0000_0000, 16'h1234));
    send_word(REQ_READ, '1);
    send_word(REQ_UNUSED, '1);
    send_word(REQ_UNUSED, '0);
    send_word(REQ_FLUSH, '1);
    send_word(REQ_FLUSH, '0);
    send_word(REQ_WRITE, to_address(32'h8000_0000, 16'h8000));
    send_word(REQ_READ, to_address(32'h7FFF_FFFF, 16'h7FFF));
    send_word(REQ_WRITE, to_address(32'h5555_5555, 16'hAAAA));
    send_word(REQ_WRITE, to_address(32'hAAAA_AAAA, 16'h5555));
    send_word(REQ_READ, to_address(32'h5555_5555, 16'h0001));
    send_word(REQ_FLUSH, '0);
    wait_for_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      steady <= (k >= RANDOM_ITEMS - STEADY_ITEMS);
      if (k == RANDOM_ITEMS / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_word(REQ_FLUSH, ADDR_W'({$urandom, $urandom}));
      end else if (pick < 9) begin
        send_word(REQ_UNUSED, ADDR_W'({$urandom, $urandom}));
      end else begin
        // A small hot set gives hits; the wide pool overfills the cache.
        if ($urandom_range(0, 4) < 2) blk = block_pool[$urandom_range(0, HOT_BLOCKS - 1)];
        else blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
        kind = ($urandom_range(0, 1) != 0) ? REQ_WRITE : REQ_READ;
        send_word(kind, to_address(blk, OFFSET_W'($urandom)));
      end
    end

    wait_for_results();
    repeat (4 * NUM_ENTRIES) @(posedge clk);
    $display("Sent %0d request words; checked %0d result words (%0d hits).",
             words_sent, results_checked, hits);
    $display("Dirty victims written back: %0d; flush write-backs: %0d.",
             dirty_evictions, flush_writebacks);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dbc_pkg.sv
hw/rtl/dbc_chan_if.sv
hw/rtl/dbc_front.sv
hw/rtl/dbc_queue.sv
hw/rtl/dbc_back.sv
hw/rtl/disk_block_cache_controller.sv
test/dbc_cache_checker.sv
test/disk_block_cache_controller_tb.sv
